// ===== sv/bft_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bft_pkg
// Shared types and constants for the tape machine: opcodes, commands,
// status codes, controller states and the execute-unit flag group.
// ----------------------------------------------------------------------------
package bft_pkg;

    // Default sizes
    localparam int PROG_DEPTH_DEF  = 4096;
    localparam int TAPE_DEPTH_DEF  = 32768;
    localparam int STACK_DEPTH_DEF = 256;

    // Width of the program_counter result field
    localparam int PC_OUT_W = 13;

    // Instruction bytes
    localparam logic [7:0] OP_INC   = 8'h2B;  // '+'
    localparam logic [7:0] OP_DEC   = 8'h2D;  // '-'
    localparam logic [7:0] OP_RIGHT = 8'h3E;  // '>'
    localparam logic [7:0] OP_LEFT  = 8'h3C;  // '<'
    localparam logic [7:0] OP_OUT   = 8'h2E;  // '.'
    localparam logic [7:0] OP_IN    = 8'h2C;  // ','
    localparam logic [7:0] OP_OPEN  = 8'h5B;  // '['
    localparam logic [7:0] OP_CLOSE = 8'h5D;  // ']'

    // Commands
    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_START = 2'd2,
        CMD_STEP  = 2'd3
    } cmd_t;

    // Result status
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_END  = 2'd1,
        ST_BRK  = 2'd2,
        ST_FULL = 2'd3
    } status_t;

    // Controller states, one-hot
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_POP   = 5'b00100,
        S_LINK  = 5'b01000,
        S_CLEAR = 5'b10000
    } state_t;

    // Side effects of one executed instruction
    typedef struct packed {
        logic cell_we;  // current cell is rewritten
        logic emit;     // output instruction
        logic taken;    // input instruction
    } exec_flags_t;

endpackage

// ===== sv/bft_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bft_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered. No reset on contents.
// ----------------------------------------------------------------------------
module bft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_reg[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

// ===== sv/bft_exec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bft_exec
// Execute unit: decodes the fetched instruction against the fetched cell and
// jump target, and produces the new cell value, pc and data pointer.
// ----------------------------------------------------------------------------
module bft_exec
    import bft_pkg::*;
#(
    parameter int PROG_DEPTH = PROG_DEPTH_DEF,
    parameter int TAPE_DEPTH = TAPE_DEPTH_DEF
) (
    input  logic [7:0]                      op,
    input  logic [7:0]                      cell_data,
    input  logic [$clog2(PROG_DEPTH)-1:0]   jump,
    input  logic [$clog2(PROG_DEPTH):0]     pc,
    input  logic [$clog2(TAPE_DEPTH)-1:0]   dp,
    input  logic [7:0]                      in_byte,
    output exec_flags_t                     flags,
    output logic [7:0]                      cell_wdata,
    output logic [$clog2(PROG_DEPTH):0]     pc_next,
    output logic [$clog2(TAPE_DEPTH)-1:0]   dp_next
);

    localparam int PAW = $clog2(PROG_DEPTH);
    localparam int PCW = PAW + 1;
    localparam int DW  = $clog2(TAPE_DEPTH);

    logic [PCW-1:0] jump_plus;

    // Jump lands just past the matching bracket
    assign jump_plus = {1'b0, jump} + PCW'(1);

    // Instruction decode
    always_comb
    begin
        flags      = '0;
        cell_wdata = cell_data;
        pc_next    = pc + PCW'(1);
        dp_next    = dp;
        case (op)
            OP_INC:
            begin
                flags.cell_we = 1'b1;
                cell_wdata    = cell_data + 8'd1;
            end
            OP_DEC:
            begin
                flags.cell_we = 1'b1;
                cell_wdata    = cell_data - 8'd1;
            end
            OP_RIGHT:
            begin
                dp_next = (dp == DW'(TAPE_DEPTH - 1)) ? '0 : dp + DW'(1);
            end
            OP_LEFT:
            begin
                dp_next = (dp == '0) ? DW'(TAPE_DEPTH - 1) : dp - DW'(1);
            end
            OP_OUT:
            begin
                flags.emit = 1'b1;
            end
            OP_IN:
            begin
                flags.cell_we = 1'b1;
                flags.taken   = 1'b1;
                cell_wdata    = in_byte;
            end
            OP_OPEN:
            begin
                if (cell_data == 8'd0)
                begin
                    pc_next = jump_plus;
                end
            end
            OP_CLOSE:
            begin
                if (cell_data != 8'd0)
                begin
                    pc_next = jump_plus;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== sv/bf_tape_machine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf_tape_machine
// Eight-instruction tape machine with on-the-fly bracket matching.
// ----------------------------------------------------------------------------
// Usage:
//   Command beats (command, symbol, input_byte) enter on cmd_valid/cmd_ready;
//   each gives exactly one result beat on rsp_valid/rsp_ready.
//   One command is worked on at a time; cmd_ready is high only while the
//   controller is idle and the result register is empty or being drained.
//   Command flow:
//     clear, load, refused step : result registered when the command is taken
//     load of a matched ']'     : result registered at once, then S_POP and
//                                 S_LINK make two jump-table writes through
//                                 the single write port
//     step                      : synchronous read of program, jump table
//                                 and tape, then execute and write-back in
//                                 S_EXEC, which posts the result
//     start                     : result offered at once; the tape is then
//                                 cleared one cell per cycle in S_CLEAR
//   After reset the tape is swept to zero before the first command is taken.
//   A stalled result holds in the result register and blocks the next
//   command until it is taken.
// ----------------------------------------------------------------------------
module bf_tape_machine
    import bft_pkg::*;
#(
    parameter int PROG_DEPTH  = PROG_DEPTH_DEF,
    parameter int TAPE_DEPTH  = TAPE_DEPTH_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    // command channel
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  logic [1:0]          command,
    input  logic [7:0]          symbol,
    input  logic [7:0]          input_byte,
    // result channel
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output logic                out_valid,
    output logic [7:0]          out_byte,
    output logic                input_taken,
    output logic [1:0]          status,
    output logic [PC_OUT_W-1:0] program_counter
);

    localparam int PAW = $clog2(PROG_DEPTH);
    localparam int PCW = PAW + 1;
    localparam int DW  = $clog2(TAPE_DEPTH);
    localparam int SAW = $clog2(STACK_DEPTH);

    // Control state
    state_t         state_reg, state_next;
    logic [PCW-1:0] len_reg, len_next;
    logic [SAW:0]   sdep_reg, sdep_next;
    logic           berr_reg, berr_next;
    logic [PCW-1:0] pc_reg, pc_next;
    logic [DW-1:0]  dp_reg, dp_next;
    logic [DW-1:0]  clr_reg, clr_next;

    // Payload holding registers
    logic [PAW-1:0] ld_addr_reg, ld_addr_next;
    logic [PAW-1:0] open_reg, open_next;
    logic [7:0]     ib_reg, ib_next;

    // Result register
    logic           rsp_valid_reg, rsp_valid_next;
    logic           ov_reg, ov_next;
    logic [7:0]     ob_reg, ob_next;
    logic           it_reg, it_next;
    status_t        st_reg, st_next;
    logic [PC_OUT_W-1:0] pco_reg, pco_next;

    // Memory ports
    logic           prog_we;
    logic [7:0]     prog_rdata;
    logic           jt_we;
    logic [PAW-1:0] jt_waddr, jt_wdata, jt_rdata;
    logic           stk_we;
    logic [PAW-1:0] stk_rdata;
    logic [SAW:0]   sdep_dec;
    logic           tape_we;
    logic [DW-1:0]  tape_waddr;
    logic [7:0]     tape_wdata, tape_rdata;

    // Execute unit
    exec_flags_t    ex_flags;
    logic [7:0]     ex_cell;
    logic [PCW-1:0] ex_pc;
    logic [DW-1:0]  ex_dp;

    logic           accept;
    logic           unbal;
    logic           err;
    logic [PCW-1:0] pc_after;
    logic [PCW+PC_OUT_W-1:0] pc_ext;

    assign cmd_ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign accept    = cmd_valid && cmd_ready;
    assign unbal     = berr_reg || (sdep_reg != '0);
    assign sdep_dec  = sdep_reg - (SAW + 1)'(1);

    // Program pc masked into the result field width
    assign pc_ext = {{PC_OUT_W{1'b0}}, pc_after};

    // Memories
    bft_ram #(.WIDTH(8), .DEPTH(PROG_DEPTH)) u_prog (
        .clk   (clk),
        .we    (prog_we),
        .waddr (len_reg[PAW-1:0]),
        .wdata (symbol),
        .raddr (pc_reg[PAW-1:0]),
        .rdata (prog_rdata)
    );

    bft_ram #(.WIDTH(PAW), .DEPTH(PROG_DEPTH)) u_jump (
        .clk   (clk),
        .we    (jt_we),
        .waddr (jt_waddr),
        .wdata (jt_wdata),
        .raddr (pc_reg[PAW-1:0]),
        .rdata (jt_rdata)
    );

    bft_ram #(.WIDTH(PAW), .DEPTH(STACK_DEPTH)) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (sdep_reg[SAW-1:0]),
        .wdata (len_reg[PAW-1:0]),
        .raddr (sdep_dec[SAW-1:0]),
        .rdata (stk_rdata)
    );

    bft_ram #(.WIDTH(8), .DEPTH(TAPE_DEPTH)) u_tape (
        .clk   (clk),
        .we    (tape_we),
        .waddr (tape_waddr),
        .wdata (tape_wdata),
        .raddr (dp_reg),
        .rdata (tape_rdata)
    );

    bft_exec #(.PROG_DEPTH(PROG_DEPTH), .TAPE_DEPTH(TAPE_DEPTH)) u_exec (
        .op         (prog_rdata),
        .cell_data  (tape_rdata),
        .jump       (jt_rdata),
        .pc         (pc_reg),
        .dp         (dp_reg),
        .in_byte    (ib_reg),
        .flags      (ex_flags),
        .cell_wdata (ex_cell),
        .pc_next    (ex_pc),
        .dp_next    (ex_dp)
    );

    // Controller
    always_comb
    begin
        state_next   = state_reg;
        len_next     = len_reg;
        sdep_next    = sdep_reg;
        berr_next    = berr_reg;
        pc_next      = pc_reg;
        dp_next      = dp_reg;
        clr_next     = clr_reg;
        ld_addr_next = ld_addr_reg;
        open_next    = open_reg;
        ib_next      = ib_reg;

        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        ov_next        = ov_reg;
        ob_next        = ob_reg;
        it_next        = it_reg;
        st_next        = st_reg;
        pco_next       = pco_reg;
        pc_after       = pc_reg;

        prog_we    = 1'b0;
        jt_we      = 1'b0;
        jt_waddr   = ld_addr_reg;
        jt_wdata   = stk_rdata;
        stk_we     = 1'b0;
        tape_we    = 1'b0;
        tape_waddr = dp_reg;
        tape_wdata = ex_cell;
        err        = berr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // immediate result unless a step goes to execute
                    rsp_valid_next = 1'b1;
                    ov_next        = 1'b0;
                    ob_next        = 8'd0;
                    it_next        = 1'b0;
                    st_next        = ST_OK;
                    case (command)
                        CMD_CLEAR:
                        begin
                            len_next  = '0;
                            sdep_next = '0;
                            berr_next = 1'b0;
                            pc_next   = '0;
                            pc_after  = '0;
                        end
                        CMD_LOAD:
                        begin
                            if (len_reg == PCW'(PROG_DEPTH))
                            begin
                                st_next = ST_FULL;
                            end
                            else
                            begin
                                prog_we  = 1'b1;
                                len_next = len_reg + PCW'(1);
                                if (symbol == OP_OPEN)
                                begin
                                    if (sdep_reg >= (SAW + 1)'(STACK_DEPTH))
                                    begin
                                        err = 1'b1;
                                    end
                                    else
                                    begin
                                        stk_we    = 1'b1;
                                        sdep_next = sdep_reg + (SAW + 1)'(1);
                                    end
                                end
                                else if (symbol == OP_CLOSE)
                                begin
                                    if (sdep_reg == '0)
                                    begin
                                        err = 1'b1;
                                    end
                                    else
                                    begin
                                        // stack read issued now, linked in S_POP and S_LINK
                                        sdep_next    = sdep_dec;
                                        ld_addr_next = len_reg[PAW-1:0];
                                        state_next   = S_POP;
                                    end
                                end
                                berr_next = err;
                                st_next   = err ? ST_BRK : ST_OK;
                            end
                        end
                        CMD_START:
                        begin
                            dp_next    = '0;
                            pc_next    = '0;
                            pc_after   = '0;
                            clr_next   = '0;
                            state_next = S_CLEAR;
                            st_next    = unbal ? ST_BRK : ST_OK;
                        end
                        CMD_STEP:
                        begin
                            if (unbal)
                            begin
                                st_next = ST_BRK;
                            end
                            else if (pc_reg >= len_reg)
                            begin
                                st_next = ST_END;
                            end
                            else
                            begin
                                // fetch issued this cycle
                                rsp_valid_next = 1'b0;
                                ib_next        = input_byte;
                                state_next     = S_EXEC;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    pco_next = pc_ext[PC_OUT_W-1:0];
                end
            end
            S_EXEC:
            begin
                // write back cell, advance pointers, post result
                tape_we        = ex_flags.cell_we;
                pc_next        = ex_pc;
                dp_next        = ex_dp;
                pc_after       = ex_pc;
                rsp_valid_next = 1'b1;
                ov_next        = ex_flags.emit;
                ob_next        = ex_flags.emit ? tape_rdata : 8'd0;
                it_next        = ex_flags.taken;
                st_next        = ST_OK;
                pco_next       = pc_ext[PC_OUT_W-1:0];
                state_next     = S_IDLE;
            end
            S_POP:
            begin
                // close bracket points back at its opener
                jt_we      = 1'b1;
                jt_waddr   = ld_addr_reg;
                jt_wdata   = stk_rdata;
                open_next  = stk_rdata;
                state_next = S_LINK;
            end
            S_LINK:
            begin
                // opener points forward at the close bracket
                jt_we      = 1'b1;
                jt_waddr   = open_reg;
                jt_wdata   = ld_addr_reg;
                state_next = S_IDLE;
            end
            S_CLEAR:
            begin
                tape_we    = 1'b1;
                tape_waddr = clr_reg;
                tape_wdata = 8'd0;
                clr_next   = clr_reg + DW'(1);
                if (clr_reg == DW'(TAPE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            len_reg       <= '0;
            sdep_reg      <= '0;
            berr_reg      <= 1'b0;
            pc_reg        <= '0;
            dp_reg        <= '0;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            sdep_reg      <= sdep_next;
            berr_reg      <= berr_next;
            pc_reg        <= pc_next;
            dp_reg        <= dp_next;
            clr_reg       <= clr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ld_addr_reg <= ld_addr_next;
        open_reg    <= open_next;
        ib_reg      <= ib_next;
        ov_reg      <= ov_next;
        ob_reg      <= ob_next;
        it_reg      <= it_next;
        st_reg      <= st_next;
        pco_reg     <= pco_next;
    end

    // Result outputs
    assign rsp_valid       = rsp_valid_reg;
    assign out_valid       = ov_reg;
    assign out_byte        = ob_reg;
    assign input_taken     = it_reg;
    assign status          = st_reg;
    assign program_counter = pco_reg;

endmodule

// ===== dv/bft_result_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bft_result_check
// Watches the command and result channels of the tape machine, predicts
// every result from its own copy of program memory, jump table, bracket
// stack and tape, and compares result beats field by field in order.
// ----------------------------------------------------------------------------
module bft_result_check
    import bft_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  logic                cmd_ready,
    input  logic [1:0]          command,
    input  logic [7:0]          symbol,
    input  logic [7:0]          input_byte,
    input  logic                rsp_valid,
    input  logic                rsp_ready,
    input  logic                out_valid,
    input  logic [7:0]          out_byte,
    input  logic                input_taken,
    input  logic [1:0]          status,
    input  logic [PC_OUT_W-1:0] program_counter,
    output int                  fail_count,
    output int                  pending,
    output int                  results_checked,
    output int                  bytes_emitted
);

    localparam int PROG_WORDS  = PROG_DEPTH_DEF;
    localparam int TAPE_CELLS  = TAPE_DEPTH_DEF;
    localparam int STACK_WORDS = STACK_DEPTH_DEF;
    localparam int SHOW_LIMIT  = 10;

    typedef struct packed {
        logic                ov;
        logic [7:0]          ob;
        logic                taken;
        status_t             st;
        logic [PC_OUT_W-1:0] pc;
    } tape_result_t;

    // Predicted machine state
    logic [7:0]  prog_mem [PROG_WORDS];
    logic [11:0] jump_addr [PROG_WORDS];
    logic [11:0] open_addrs [STACK_WORDS];
    logic [7:0]  tape [TAPE_CELLS];
    logic [14:0] data_ptr;
    int          open_depth;
    int          prog_len;
    int          pc;
    bit          bracket_err;

    tape_result_t expected_results [$];

    function automatic void wipe_tape();
        for (int i = 0; i < TAPE_CELLS; i++)
        begin
            tape[i] = 8'h00;
        end
        data_ptr = '0;
    endfunction

    // Append one program byte, matching brackets as they arrive
    function automatic status_t load_symbol(logic [7:0] sym);
        int open_at;
        if (prog_len >= PROG_WORDS)
        begin
            return ST_FULL;
        end
        prog_mem[prog_len] = sym;
        if (sym == OP_OPEN)
        begin
            if (open_depth >= STACK_WORDS)
            begin
                bracket_err = 1'b1;
            end
            else
            begin
                open_addrs[open_depth] = prog_len[11:0];
                open_depth++;
            end
        end
        else if (sym == OP_CLOSE)
        begin
            if (open_depth == 0)
            begin
                bracket_err = 1'b1;
            end
            else
            begin
                open_depth--;
                open_at = open_addrs[open_depth];
                jump_addr[prog_len] = open_addrs[open_depth];
                jump_addr[open_at] = prog_len[11:0];
            end
        end
        prog_len++;
        return bracket_err ? ST_BRK : ST_OK;
    endfunction

    // Expected result of one command beat; updates the predicted state
    function automatic tape_result_t apply_command(cmd_t c, logic [7:0] sym,
                                                   logic [7:0] ib);
        tape_result_t r;
        logic [7:0]   op;
        r = '0;
        case (c)
            CMD_CLEAR:
            begin
                prog_len    = 0;
                open_depth  = 0;
                bracket_err = 1'b0;
                pc          = 0;
            end
            CMD_LOAD:
            begin
                r.st = load_symbol(sym);
            end
            CMD_START:
            begin
                wipe_tape();
                pc   = 0;
                r.st = (bracket_err || open_depth != 0) ? ST_BRK : ST_OK;
            end
            default:
            begin
                if (bracket_err || open_depth != 0)
                begin
                    r.st = ST_BRK;
                end
                else if (pc >= prog_len)
                begin
                    r.st = ST_END;
                end
                else
                begin
                    op = prog_mem[pc];
                    case (op)
                        OP_INC:   tape[data_ptr] = tape[data_ptr] + 8'd1;
                        OP_DEC:   tape[data_ptr] = tape[data_ptr] - 8'd1;
                        // 15-bit pointer wraps over the whole tape
                        OP_RIGHT: data_ptr = data_ptr + 15'd1;
                        OP_LEFT:  data_ptr = data_ptr - 15'd1;
                        OP_OUT:
                        begin
                            r.ov = 1'b1;
                            r.ob = tape[data_ptr];
                        end
                        OP_IN:
                        begin
                            tape[data_ptr] = ib;
                            r.taken        = 1'b1;
                        end
                        OP_OPEN:
                        begin
                            if (tape[data_ptr] == 8'h00)
                            begin
                                pc = jump_addr[pc];
                            end
                        end
                        OP_CLOSE:
                        begin
                            if (tape[data_ptr] != 8'h00)
                            begin
                                pc = jump_addr[pc];
                            end
                        end
                        default: ;
                    endcase
                    pc++;
                end
            end
        endcase
        r.pc = pc[PC_OUT_W-1:0];
        return r;
    endfunction

    task automatic note_failure(string what, tape_result_t want, tape_result_t got);
        fail_count++;
        if (fail_count <= SHOW_LIMIT)
        begin
            $display("[%0t] %s", $realtime, what);
            $display("    want: out_valid=%0d out_byte=%02h input_taken=%0d status=%0d pc=%0d",
                     want.ov, want.ob, want.taken, want.st, want.pc);
            $display("    got : out_valid=%0d out_byte=%02h input_taken=%0d status=%0d pc=%0d",
                     got.ov, got.ob, got.taken, got.st, got.pc);
        end
    endtask

    // Result beats are checked before the command beat of the same edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        tape_result_t got;
        tape_result_t want;
        if (!rst_n)
        begin
            expected_results.delete();
            wipe_tape();
            open_depth      = 0;
            prog_len        = 0;
            pc              = 0;
            bracket_err     = 1'b0;
            fail_count      = 0;
            results_checked = 0;
            bytes_emitted   = 0;
            pending        <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                got.ov    = out_valid;
                got.ob    = out_byte;
                got.taken = input_taken;
                got.st    = status_t'(status);
                got.pc    = program_counter;
                results_checked++;
                if (got.ov === 1'b1)
                begin
                    bytes_emitted++;
                end
                if (expected_results.size() == 0)
                begin
                    note_failure("result beat with nothing expected", '0, got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        note_failure("result mismatch", want, got);
                    end
                end
            end
            if (cmd_valid && cmd_ready)
            begin
                expected_results.push_back(
                    apply_command(cmd_t'(command), symbol, input_byte));
            end
            pending <= expected_results.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives command beats into the tape machine: a short hand-written program
// with loops, pointer wrap and bracket errors, an overflow of the bracket
// stack, then random programs with balanced brackets mixed with stray
// commands, under changing sender idle and receiver stall rates. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import bft_pkg::*;

    localparam int RANDOM_BEATS = 1280;

    logic                clk;
    logic                rst_n       = 1'b0;
    logic                cmd_valid   = 1'b0;
    logic                cmd_ready;
    cmd_t                command     = CMD_CLEAR;
    logic [7:0]          symbol      = 8'h00;
    logic [7:0]          input_byte  = 8'h00;
    logic                rsp_valid;
    logic                rsp_ready   = 1'b0;
    logic                out_valid;
    logic [7:0]          out_byte;
    logic                input_taken;
    logic [1:0]          status;
    logic [PC_OUT_W-1:0] program_counter;

    int fail_count;
    int pending;
    int results_checked;
    int bytes_emitted;

    int idle_pct   = 0;
    int stall_pct  = 0;
    int beats_sent = 0;
    int starts_sent = 0;
    int starts_left = 0;

    bf_tape_machine uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_valid),
        .cmd_ready       (cmd_ready),
        .command         (command),
        .symbol          (symbol),
        .input_byte      (input_byte),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .out_valid       (out_valid),
        .out_byte        (out_byte),
        .input_taken     (input_taken),
        .status          (status),
        .program_counter (program_counter)
    );

    bft_result_check result_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_valid),
        .cmd_ready       (cmd_ready),
        .command         (command),
        .symbol          (symbol),
        .input_byte      (input_byte),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .out_valid       (out_valid),
        .out_byte        (out_byte),
        .input_taken     (input_taken),
        .status          (status),
        .program_counter (program_counter),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .bytes_emitted   (bytes_emitted)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Receiver back-pressure
    always @(posedge clk)
    begin
        rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Each start sweeps the whole tape, so the bound is generous
    initial
    begin
        #80_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // 0 no idling, 1 sender idles, 2 receiver stalls, 3 both
    task automatic set_phase(int p);
        idle_pct  = (p == 1) ? 49 : (p == 3) ? 14 : 0;
        stall_pct = (p == 2) ? 49 : (p == 3) ? 14 : 0;
    endtask

    // One command beat; returns at the edge that accepts it
    task automatic issue_command(cmd_t c, logic [7:0] s, logic [7:0] b);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            cmd_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
        end
        cmd_valid  <= 1'b1;
        command    <= c;
        symbol     <= s;
        input_byte <= b;
        do @(posedge clk); while (!cmd_ready);
        beats_sent++;
        if (c == CMD_START)
        begin
            starts_sent++;
        end
    endtask

    // Random program with balanced brackets, sometimes broken on purpose
    task automatic run_program();
        logic [7:0] prog [$];
        int         len;
        int         open_cnt;
        int         roll;
        int         steps;
        len      = $urandom_range(1, 24);
        open_cnt = 0;
        for (int i = 0; i < len; i++)
        begin
            roll = $urandom_range(0, 99);
            if (open_cnt > 0 && len - i <= open_cnt)
            begin
                prog.push_back(OP_CLOSE);
                open_cnt--;
            end
            else if (roll < 14 && len - i > open_cnt + 1)
            begin
                prog.push_back(OP_OPEN);
                open_cnt++;
            end
            else if (roll < 28 && open_cnt > 0)
            begin
                prog.push_back(OP_CLOSE);
                open_cnt--;
            end
            else if (roll < 34)
            begin
                prog.push_back(8'($urandom));
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0:       prog.push_back(OP_INC);
                    1:       prog.push_back(OP_DEC);
                    2:       prog.push_back(OP_RIGHT);
                    3:       prog.push_back(OP_LEFT);
                    4:       prog.push_back(OP_OUT);
                    default: prog.push_back(OP_IN);
                endcase
            end
        end
        if ($urandom_range(0, 7) == 0)
        begin
            prog.insert($urandom_range(0, prog.size()),
                        $urandom_range(0, 1) ? OP_OPEN : OP_CLOSE);
        end

        // Mostly a fresh program; now and then appended to the old one
        if ($urandom_range(0, 3) != 0)
        begin
            issue_command(CMD_CLEAR, 8'($urandom), 8'($urandom));
        end
        foreach (prog[i])
        begin
            issue_command(CMD_LOAD, prog[i], 8'($urandom));
        end
        if (starts_left > 0 && $urandom_range(0, 3) == 0)
        begin
            starts_left--;
            issue_command(CMD_START, 8'($urandom), 8'($urandom));
        end
        steps = $urandom_range(len, 3 * len + 10);
        repeat (steps)
        begin
            issue_command(CMD_STEP, 8'($urandom), 8'($urandom));
        end
    endtask

    // Stray commands with random payload
    task automatic noise_burst();
        cmd_t c;
        repeat ($urandom_range(1, 6))
        begin
            c = cmd_t'($urandom_range(0, 3));
            if (c == CMD_START)
            begin
                if (starts_left > 0)
                begin
                    starts_left--;
                end
                else
                begin
                    c = CMD_STEP;
                end
            end
            issue_command(c, 8'($urandom), 8'($urandom));
        end
    endtask

    initial
    begin
        logic [7:0] demo [$];
        int seq_no;
        int random_base;

        // wraps left off cell 0, loops through [-], skips [] on a zero cell
        demo = '{OP_LEFT, OP_INC, OP_OUT, OP_IN, OP_OPEN, OP_DEC,
                 OP_CLOSE, OP_RIGHT, OP_OUT, OP_OPEN, OP_CLOSE};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: close with empty stack, refused step, then a real program
        set_phase(0);
        issue_command(CMD_LOAD, OP_CLOSE, 8'h00);
        issue_command(CMD_STEP, 8'hFF, 8'hFF);
        issue_command(CMD_CLEAR, 8'h00, 8'h00);
        foreach (demo[i])
        begin
            issue_command(CMD_LOAD, demo[i], 8'h00);
        end
        issue_command(CMD_START, 8'h00, 8'h00);
        for (int i = 0; i < 13; i++)
        begin
            // the ',' at step 3 stores 2, so the loop runs twice
            issue_command(CMD_STEP, 8'hFF, (i == 3) ? 8'h02 : 8'hFF);
        end

        // Stack overflow on the 257th '[', then one more byte and a step
        set_phase(3);
        issue_command(CMD_CLEAR, 8'h00, 8'h00);
        for (int i = 0; i < STACK_DEPTH_DEF + 2; i++)
        begin
            issue_command(CMD_LOAD,
                          (i <= STACK_DEPTH_DEF) ? OP_OPEN : 8'($urandom),
                          8'($urandom));
        end
        issue_command(CMD_STEP, 8'($urandom), 8'($urandom));

        // Random programs and noise across all idling phases
        starts_left = 8;
        seq_no      = 0;
        random_base = beats_sent;
        while (beats_sent - random_base < RANDOM_BEATS)
        begin
            set_phase(seq_no % 4);
            if ($urandom_range(0, 99) < 85)
            begin
                run_program();
            end
            else
            begin
                noise_burst();
            end
            seq_no++;
        end
        cmd_valid <= 1'b0;

        // Drain, then allow for a late stray beat
        stall_pct = 0;
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);

        $display("Sent %0d command beats, %0d of them tape-clearing starts, incl. a stack overflow.",
                 beats_sent, starts_sent);
        $display("Checked %0d results with %0d output bytes; %0d failures.",
                 results_checked, bytes_emitted, fail_count);
        if (fail_count == 0 && pending == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/bft_pkg.sv
sv/bft_ram.sv
sv/bft_exec.sv
sv/bf_tape_machine.sv
dv/bft_result_check.sv
dv/testbench.sv
